// ----- hw/rtl/spq_pkg.sv -----
// Shared types, constants and helpers for the sorted-array priority queue.
`default_nettype none

package spq_pkg;

  // Default number of slots in the cell chain.
  localparam int CAPACITY_DEF = 128;

  // Field widths of the channels.
  localparam int ID_W     = 16;
  localparam int PRIO_W   = 4;
  localparam int ACTION_W = 2;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 8;

  // Legal priority range; a lower value is more urgent.
  localparam logic [PRIO_W-1:0] PRIO_MIN = 4'd1;
  localparam logic [PRIO_W-1:0] PRIO_MAX = 4'd10;

  // Slot identifiers are gathered for an update in groups of this many cells.
  localparam int SEL_GROUP = 32;

  // Operation codes of the input channel.
  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_POP    = 2'd1,
    ACT_UPDATE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Command that all cells of the chain see in one cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  // Controller states.
  typedef enum logic {
    S_IDLE,
    S_REINSERT
  } state_t;

  // One stored entry.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // Broadcast command to the cell chain.
  typedef struct packed {
    cell_op_t op;
    logic     tie_before;
    entry_t   entry;
  } cell_cmd_t;

  // Bring a requested priority into the legal range.
  function automatic logic [PRIO_W-1:0] clamp_prio(input logic [PRIO_W-1:0] p);
    logic [PRIO_W-1:0] r;
    r = p;
    if (p < PRIO_MIN) begin
      r = PRIO_MIN;
    end else if (p > PRIO_MAX) begin
      r = PRIO_MAX;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/spq_cell.sv -----
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
`default_nettype none

module spq_cell #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
  parameter int IDX      = 0
) (
  input  wire                                      clk,
  input  wire spq_pkg::cell_cmd_t                  cmd_i,
  input  wire [((($clog2(CAPACITY+1)) > spq_pkg::OCC_W) ?
                ($clog2(CAPACITY+1)) : spq_pkg::OCC_W)-1:0] count_i,
  input  wire [((($clog2(CAPACITY+1)) > spq_pkg::OCC_W) ?
                ($clog2(CAPACITY+1)) : spq_pkg::OCC_W)-1:0] pos_i,
  input  wire spq_pkg::entry_t                     left_i,
  input  wire                                      left_gt_i,
  input  wire spq_pkg::entry_t                     right_i,
  output spq_pkg::entry_t                          entry_o,
  output logic                                     gt_o,
  output logic [spq_pkg::ID_W-1:0]                 sel_id_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > spq_pkg::OCC_W) ? CW : spq_pkg::OCC_W;
  localparam logic [XW-1:0] MY_IDX = XW'(IDX);

  spq_pkg::entry_t entry_r;
  spq_pkg::entry_t entry_nxt;
  logic            occ;
  logic            tie;

  // The slot holds a live entry when it lies below the fill count.
  assign occ = (MY_IDX < count_i);
  // Entries that stood right of an updated slot also give way to equal values.
  assign tie = cmd_i.tie_before && (MY_IDX >= pos_i);

  // This slot must move right when the new entry belongs in front of it.
  always_comb begin
    if (tie) begin
      gt_o = occ && (entry_r.prio >= cmd_i.entry.prio);
    end else begin
      gt_o = occ && (entry_r.prio > cmd_i.entry.prio);
    end
  end

  // Next slot content from the broadcast command and the neighbors.
  always_comb begin
    entry_nxt = entry_r;
    case (cmd_i.op)
      spq_pkg::CELL_INSERT: begin
        if (left_gt_i) begin
          entry_nxt = left_i;
        end else if (!occ || gt_o) begin
          entry_nxt = cmd_i.entry;
        end
      end
      spq_pkg::CELL_REMOVE: begin
        if (MY_IDX >= pos_i) begin
          entry_nxt = right_i;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o  = entry_r;
  // Only the addressed slot puts its identifier on the gather lines.
  assign sel_id_o = (MY_IDX == pos_i) ? entry_r.id : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_array_priority_queue.sv -----
// Top level of the sorted-array priority queue: controller and cell chain.
//
// Usage:
// The input channel carries one operation per transfer: insert an entry,
// pop the head entry, or set a new priority on the entry at a position.
// Each operation gives exactly one result transfer on the output channel,
// with a status, the popped entry (zero unless a pop succeeds) and the
// number of entries held afterwards.
// Insert and pop are done by the whole cell chain in the cycle of the
// input transfer; the result appears in the output register in the next
// cycle, so one operation per cycle is sustained while the output flows.
// An update first pulls the entry out of its slot and captures its
// identifier in group registers, then inserts it again at its new place
// in the reinsert state, during which the input is stalled.
// A new operation is taken while the output register is being emptied,
// and is stalled while a result waits under output stall.
// Reset empties the queue by clearing the fill count, the state and the
// output valid; slots are not cleared and are never read before written.
`default_nettype none

module sorted_array_priority_queue #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire [spq_pkg::ACTION_W-1:0]    in_action,
  input  wire [spq_pkg::ID_W-1:0]        in_entry_id,
  input  wire [spq_pkg::PRIO_W-1:0]      in_entry_priority,
  input  wire [spq_pkg::POS_W-1:0]       in_position,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [spq_pkg::STATUS_W-1:0]   out_status,
  output logic [spq_pkg::ID_W-1:0]       out_head_id,
  output logic [spq_pkg::PRIO_W-1:0]     out_head_priority,
  output logic [spq_pkg::OCC_W-1:0]      out_occupancy
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > spq_pkg::OCC_W) ? CW : spq_pkg::OCC_W;
  localparam int G  = spq_pkg::SEL_GROUP;
  localparam int NG = (CAPACITY + G - 1) / G;

  // Control registers.
  spq_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [XW-1:0]    pos_r;
  logic [spq_pkg::PRIO_W-1:0] prio_r;
  logic             out_valid_r;

  // Result registers.
  spq_pkg::status_t           out_status_r;
  logic [spq_pkg::ID_W-1:0]   out_head_id_r;
  logic [spq_pkg::PRIO_W-1:0] out_head_prio_r;
  logic [spq_pkg::OCC_W-1:0]  out_occ_r;

  // Identifier gather registers, one per group of cells.
  logic [spq_pkg::ID_W-1:0] grp_r [NG];
  logic [spq_pkg::ID_W-1:0] grp_nxt [NG];

  // Chain wiring.
  spq_pkg::entry_t          entries [CAPACITY];
  logic                     gts [CAPACITY];
  logic [spq_pkg::ID_W-1:0] sel_ids [CAPACITY];
  logic [spq_pkg::ID_W-1:0] sel_pad [NG*G];

  spq_pkg::cell_cmd_t cmd;
  logic [XW-1:0]      cell_pos;
  logic [XW-1:0]      count_x;
  logic [XW-1:0]      pos_x;
  logic [XW-1:0]      count_nxt_x;
  logic [spq_pkg::PRIO_W-1:0] prio_c;
  logic [spq_pkg::ID_W-1:0]   gathered_id;
  logic               in_xfer;
  logic               load_out;
  logic               upd_start;
  spq_pkg::status_t           res_status;
  logic [spq_pkg::ID_W-1:0]   res_head_id;
  logic [spq_pkg::PRIO_W-1:0] res_head_prio;

  assign count_x     = XW'(count_r);
  assign pos_x       = XW'(in_position);
  assign count_nxt_x = XW'(count_nxt);
  assign prio_c      = spq_pkg::clamp_prio(in_entry_priority);

  // A new operation waits for the reinsert cycle and for a blocked result.
  assign in_stall = (state_r != spq_pkg::S_IDLE) || (out_valid_r && out_stall);
  assign in_xfer  = in_valid && !in_stall;

  // Final OR over the group registers gives the identifier being moved.
  always_comb begin
    gathered_id = '0;
    for (int g = 0; g < NG; g++) begin
      gathered_id = gathered_id | grp_r[g];
    end
  end

  // Per-group OR of the addressed slot's identifier.
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < G; k++) begin
        grp_nxt[g] = grp_nxt[g] | sel_pad[g*G + k];
      end
    end
  end

  // Controller: decode the operation, drive the chain and form the result.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    cmd.op        = spq_pkg::CELL_HOLD;
    cmd.tie_before = 1'b0;
    cmd.entry.id  = in_entry_id;
    cmd.entry.prio = prio_c;
    cell_pos      = pos_x;
    load_out      = 1'b0;
    upd_start     = 1'b0;
    res_status    = spq_pkg::ST_OK;
    res_head_id   = '0;
    res_head_prio = '0;
    case (state_r)
      spq_pkg::S_IDLE: begin
        if (in_xfer) begin
          case (spq_pkg::action_t'(in_action))
            spq_pkg::ACT_INSERT: begin
              load_out = 1'b1;
              if (count_r == CW'(CAPACITY)) begin
                res_status = spq_pkg::ST_FULL;
              end else begin
                cmd.op    = spq_pkg::CELL_INSERT;
                count_nxt = count_r + 1'b1;
              end
            end
            spq_pkg::ACT_POP: begin
              load_out = 1'b1;
              if (count_r == '0) begin
                res_status = spq_pkg::ST_EMPTY;
              end else begin
                cmd.op        = spq_pkg::CELL_REMOVE;
                cell_pos      = '0;
                res_head_id   = entries[0].id;
                res_head_prio = entries[0].prio;
                count_nxt     = count_r - 1'b1;
              end
            end
            spq_pkg::ACT_UPDATE: begin
              if (count_r == '0) begin
                load_out   = 1'b1;
                res_status = spq_pkg::ST_EMPTY;
              end else if (pos_x >= count_x) begin
                load_out   = 1'b1;
                res_status = spq_pkg::ST_RANGE;
              end else begin
                cmd.op    = spq_pkg::CELL_REMOVE;
                count_nxt = count_r - 1'b1;
                upd_start = 1'b1;
                state_nxt = spq_pkg::S_REINSERT;
              end
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      spq_pkg::S_REINSERT: begin
        cmd.op         = spq_pkg::CELL_INSERT;
        cmd.tie_before = 1'b1;
        cmd.entry.id   = gathered_id;
        cmd.entry.prio = prio_r;
        cell_pos       = pos_r;
        count_nxt      = count_r + 1'b1;
        load_out       = 1'b1;
        state_nxt      = spq_pkg::S_IDLE;
      end
      default: begin
        state_nxt = spq_pkg::S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spq_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, loaded only when a new result is formed.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r    <= res_status;
      out_head_id_r   <= res_head_id;
      out_head_prio_r <= res_head_prio;
      out_occ_r       <= count_nxt_x[spq_pkg::OCC_W-1:0];
    end
  end

  // Update operands and the gathered identifier groups.
  always_ff @(posedge clk) begin
    if (upd_start) begin
      pos_r  <= pos_x;
      prio_r <= prio_c;
      for (int g = 0; g < NG; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
  end

  // Cell chain.
  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      spq_pkg::entry_t left_e;
      spq_pkg::entry_t right_e;
      logic            left_gt;
      if (i == 0) begin : g_first
        assign left_e  = '0;
        assign left_gt = 1'b0;
      end else begin : g_mid
        assign left_e  = entries[i-1];
        assign left_gt = gts[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign right_e = entries[i];
      end else begin : g_inner
        assign right_e = entries[i+1];
      end
      spq_cell #(
        .CAPACITY (CAPACITY),
        .IDX      (i)
      ) u_cell (
        .clk       (clk),
        .cmd_i     (cmd),
        .count_i   (count_x),
        .pos_i     (cell_pos),
        .left_i    (left_e),
        .left_gt_i (left_gt),
        .right_i   (right_e),
        .entry_o   (entries[i]),
        .gt_o      (gts[i]),
        .sel_id_o  (sel_ids[i])
      );
    end
    for (i = 0; i < NG*G; i++) begin : g_pad
      if (i < CAPACITY) begin : g_used
        assign sel_pad[i] = sel_ids[i];
      end else begin : g_unused
        assign sel_pad[i] = '0;
      end
    end
  endgenerate

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_head_id       = out_head_id_r;
  assign out_head_priority = out_head_prio_r;
  assign out_occupancy     = out_occ_r;

endmodule

`default_nettype wire

// ----- hw/rtl/spq_checker.sv -----
// Port-level checks for the sorted-array priority queue, bound to the top level.
`default_nettype none

module spq_checker #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          out_valid,
  input wire                          out_stall,
  input wire [spq_pkg::STATUS_W-1:0]  out_status,
  input wire [spq_pkg::ID_W-1:0]      out_head_id,
  input wire [spq_pkg::PRIO_W-1:0]    out_head_priority,
  input wire [spq_pkg::OCC_W-1:0]     out_occupancy
);

  // No result is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status) &&
      $stable(out_head_id) && $stable(out_head_priority) && $stable(out_occupancy)))
    else $error("stalled result changed");

  // A refused insert reports a full queue.
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == spq_pkg::ST_FULL) |->
      (out_occupancy == spq_pkg::OCC_W'(CAPACITY)))
    else $error("full status with wrong occupancy");

  // An empty status reports no entries and no head.
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == spq_pkg::ST_EMPTY) |->
      (out_occupancy == '0 && out_head_id == '0 && out_head_priority == '0))
    else $error("empty status with entries or head");

  // A popped head always carries a legal priority.
  a_head_prio: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_head_priority != '0) |->
      (out_status == spq_pkg::ST_OK && out_head_priority <= spq_pkg::PRIO_MAX))
    else $error("head priority out of range");

endmodule

bind sorted_array_priority_queue spq_checker #(
  .CAPACITY (CAPACITY)
) u_spq_checker (.*);

`default_nettype wire
